// File: rtl/core/double_ended_queue_macros.svh
// assertion macros for the double-ended queue checker
// no dependencies; included by the checker file
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// same-cycle implication, sampled on the rising clock edge
`define DQ_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("deque check failed");

// next-cycle implication, sampled on the rising clock edge
`define DQ_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("deque check failed");

`endif

// File: rtl/core/dq_pkg.sv
// shared types and codes of the double-ended queue
// no dependencies; imported by every module of the block
`default_nettype none

package dq_pkg;

   localparam int DATA_W   = 32;
   localparam int OP_W     = 3;
   localparam int STATUS_W = 2;
   localparam int ACT_W    = 3;

   // request operation codes
   localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
   localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
   localparam logic [OP_W-1:0] OP_DUMP       = 3'd4;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   // actions broadcast to the cell chain
   localparam logic [ACT_W-1:0] ACT_HOLD       = 3'd0;
   localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 3'd1;
   localparam logic [ACT_W-1:0] ACT_PUSH_BACK  = 3'd2;
   localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 3'd3;
   localparam logic [ACT_W-1:0] ACT_POP_BACK   = 3'd4;
   localparam logic [ACT_W-1:0] ACT_ROTATE     = 3'd5;

   typedef struct packed {
      logic [ACT_W-1:0]         action;
      logic signed [DATA_W-1:0] value;
   } cmd_type;

endpackage

`default_nettype wire

// File: rtl/core/double_ended_queue.sv
// Push, pop: result the cycle after the request is taken; one request per cycle unless busy.
// Dump of N entries: N results without gaps, front to back, each from the response register;
// busy is high while the cell chain rotates one step per cycle.
// Results cannot be stalled. Reset (synchronous) empties the queue; stored words are
// not cleared.
// top level: control, entry counter, response register and the cell chain
`default_nettype none

module double_ended_queue import dq_pkg::*; #(
   parameter int CAPACITY = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [OP_W-1:0]            req_op,
   input  logic signed [DATA_W-1:0]   req_value,
   output logic                       rsp_strobe,
   output logic signed [DATA_W-1:0]   rsp_item,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic                       rsp_last
);

   localparam int CW = $clog2(CAPACITY + 1);

   cmd_type                  cmd;
   logic signed [DATA_W-1:0] cell_data [CAPACITY];
   logic [CAPACITY-1:0]      cell_occ;
   logic [CAPACITY-1:0]      cell_tail;
   logic signed [DATA_W-1:0] tail_data;
   logic                     full;
   logic                     empty;
   logic                     accept;

   logic [CW-1:0]            count_ff;
   logic [CW-1:0]            count_in;
   logic [CW-1:0]            remain_ff;
   logic [CW-1:0]            remain_in;
   logic                     dumping_ff;
   logic                     dumping_in;

   logic                     strobe_ff;
   logic                     strobe_in;
   logic signed [DATA_W-1:0] item_ff;
   logic signed [DATA_W-1:0] item_in;
   logic [STATUS_W-1:0]      status_ff;
   logic [STATUS_W-1:0]      status_in;
   logic                     last_ff;
   logic                     last_in;

   assign busy       = dumping_ff;
   assign accept     = start & ~dumping_ff;
   assign full       = cell_occ[CAPACITY-1];
   assign empty      = ~cell_occ[0];
   assign rsp_strobe = strobe_ff;
   assign rsp_item   = item_ff;
   assign rsp_status = status_ff;
   assign rsp_last   = last_ff;

   // cell chain, front at index zero
   for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic signed [DATA_W-1:0] l_data;
      logic                     l_occ;
      logic signed [DATA_W-1:0] r_data;
      logic                     r_occ;

      if (gi == 0) begin : g_head
         assign l_data = cmd.value;
         assign l_occ  = 1'b1;
      end else begin : g_body
         assign l_data = cell_data[gi-1];
         assign l_occ  = cell_occ[gi-1];
      end

      if (gi == CAPACITY - 1) begin : g_end
         assign r_data = '0;
         assign r_occ  = 1'b0;
      end else begin : g_mid
         assign r_data = cell_data[gi+1];
         assign r_occ  = cell_occ[gi+1];
      end

      dq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .left_data  (l_data),
         .left_occ   (l_occ),
         .right_data (r_data),
         .right_occ  (r_occ),
         .wrap_data  (cell_data[0]),
         .data       (cell_data[gi]),
         .occ        (cell_occ[gi]),
         .tail       (cell_tail[gi])
      );
   end

   // back word: one-hot tail select
   always_comb begin
      tail_data = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (cell_tail[i]) begin
            tail_data = tail_data | cell_data[i];
         end
      end
   end

   // chain action, counter, dump sequencer and response
   always_comb begin
      cmd.action = ACT_HOLD;
      cmd.value  = req_value;
      count_in   = count_ff;
      remain_in  = remain_ff;
      dumping_in = dumping_ff;
      strobe_in  = 1'b0;
      item_in    = '0;
      status_in  = ST_OK;
      last_in    = 1'b1;
      if (dumping_ff) begin
         cmd.action = ACT_ROTATE;
         strobe_in  = 1'b1;
         item_in    = cell_data[0];
         last_in    = (remain_ff == CW'(1));
         remain_in  = remain_ff - CW'(1);
         dumping_in = (remain_ff != CW'(1));
      end else if (accept) begin
         case (req_op)
            OP_PUSH_FRONT: begin
               strobe_in = 1'b1;
               if (full) begin
                  status_in = ST_FULL;
               end else begin
                  cmd.action = ACT_PUSH_FRONT;
                  count_in   = count_ff + CW'(1);
               end
            end
            OP_PUSH_BACK: begin
               strobe_in = 1'b1;
               if (full) begin
                  status_in = ST_FULL;
               end else begin
                  cmd.action = ACT_PUSH_BACK;
                  count_in   = count_ff + CW'(1);
               end
            end
            OP_POP_FRONT: begin
               strobe_in = 1'b1;
               if (empty) begin
                  status_in = ST_EMPTY;
               end else begin
                  cmd.action = ACT_POP_FRONT;
                  item_in    = cell_data[0];
                  count_in   = count_ff - CW'(1);
               end
            end
            OP_POP_BACK: begin
               strobe_in = 1'b1;
               if (empty) begin
                  status_in = ST_EMPTY;
               end else begin
                  cmd.action = ACT_POP_BACK;
                  item_in    = tail_data;
                  count_in   = count_ff - CW'(1);
               end
            end
            OP_DUMP: begin
               if (empty) begin
                  strobe_in = 1'b1;
                  status_in = ST_EMPTY;
               end else begin
                  dumping_in = 1'b1;
                  remain_in  = count_ff;
               end
            end
            default: begin
               strobe_in = 1'b0;
            end
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         remain_ff  <= '0;
         dumping_ff <= 1'b0;
         strobe_ff  <= 1'b0;
      end else begin
         count_ff   <= count_in;
         remain_ff  <= remain_in;
         dumping_ff <= dumping_in;
         strobe_ff  <= strobe_in;
      end
   end

   // response payload, no reset
   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      status_ff <= status_in;
      last_ff   <= last_in;
   end

endmodule

`default_nettype wire

// File: rtl/core/dq_cell.sv
// one storage cell of the deque chain: a word and its occupied flag
// depends on dq_pkg for the command struct and action codes
`default_nettype none

module dq_cell import dq_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   input  logic signed [DATA_W-1:0] left_data,
   input  logic                     left_occ,
   input  logic signed [DATA_W-1:0] right_data,
   input  logic                     right_occ,
   input  logic signed [DATA_W-1:0] wrap_data,
   output logic signed [DATA_W-1:0] data,
   output logic                     occ,
   output logic                     tail
);

   logic signed [DATA_W-1:0] data_ff;
   logic signed [DATA_W-1:0] data_in;
   logic                     occ_ff;
   logic                     occ_in;

   assign data = data_ff;
   assign occ  = occ_ff;
   // last occupied cell of the chain
   assign tail = occ_ff & ~right_occ;

   // next word and flag from the broadcast action
   always_comb begin
      data_in = data_ff;
      occ_in  = occ_ff;
      case (cmd.action)
         ACT_PUSH_FRONT: begin
            data_in = left_data;
            occ_in  = left_occ;
         end
         ACT_PUSH_BACK: begin
            if (~occ_ff & left_occ) begin
               data_in = cmd.value;
               occ_in  = 1'b1;
            end
         end
         ACT_POP_FRONT: begin
            data_in = right_data;
            occ_in  = right_occ;
         end
         ACT_POP_BACK: begin
            if (tail) begin
               occ_in = 1'b0;
            end
         end
         ACT_ROTATE: begin
            if (tail) begin
               data_in = wrap_data;
            end else if (occ_ff) begin
               data_in = right_data;
            end
         end
         default: begin
            data_in = data_ff;
            occ_in  = occ_ff;
         end
      endcase
   end

   // word register, no reset
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   // occupied flag
   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/dq_checker.sv
// port-level checks of the double-ended queue, bound to the top level
// depends on dq_pkg and double_ended_queue_macros.svh
`default_nettype none
`include "double_ended_queue_macros.svh"

module dq_checker import dq_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     start,
   input logic                     busy,
   input logic [OP_W-1:0]          req_op,
   input logic                     rsp_strobe,
   input logic signed [DATA_W-1:0] rsp_item,
   input logic [STATUS_W-1:0]      rsp_status,
   input logic                     rsp_last
);

   logic take;
   logic end_op;

   assign take   = start & ~busy;
   assign end_op = (req_op == OP_PUSH_FRONT) || (req_op == OP_PUSH_BACK) ||
                   (req_op == OP_POP_FRONT) || (req_op == OP_POP_BACK);

   // push or pop answers next cycle with a single final result
   `DQ_ASSERT_NEXT(a_end_op_answer, take && end_op, rsp_strobe && rsp_last)

   // unused codes give nothing
   `DQ_ASSERT_NEXT(a_unused_silent, take && (req_op != OP_DUMP) && !end_op, !rsp_strobe)

   // refused request carries zero and ends the stream
   `DQ_ASSERT_NOW(a_refused_zero, rsp_strobe && (rsp_status != ST_OK), (rsp_item == 0) && rsp_last)

   // dump stream has no gaps
   `DQ_ASSERT_NEXT(a_dump_gapless, rsp_strobe && !rsp_last, rsp_strobe)

endmodule

bind double_ended_queue dq_checker u_dq_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_op     (req_op),
   .rsp_strobe (rsp_strobe),
   .rsp_item   (rsp_item),
   .rsp_status (rsp_status),
   .rsp_last   (rsp_last)
);

`default_nettype wire

// File: tb/sv/tb_double_ended_queue.sv
// self-checking testbench for the double-ended queue: directed corner cases, then random traffic
// depends on dq_pkg and double_ended_queue; results are checked against an in-bench deque model
`default_nettype none

module tb_double_ended_queue import dq_pkg::*;;

   localparam int CAPACITY     = 16;
   localparam int RANDOM_ITEMS = 225;
   localparam int DRAIN_CYCLES = 24;
   localparam int CYCLE_LIMIT  = 200000;

   // op codes the block ignores
   localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd5;
   localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

   localparam logic signed [DATA_W-1:0] WORD_MIN  = 32'sh8000_0000;
   localparam logic signed [DATA_W-1:0] WORD_MAX  = 32'sh7fff_ffff;
   localparam logic signed [DATA_W-1:0] WORD_ONES = 32'shffff_ffff;

   typedef struct {
      logic signed [DATA_W-1:0] item;
      logic [STATUS_W-1:0]      status;
      logic                     last;
   } deque_result_type;

   logic                     clock     = 1'b0;
   logic                     reset     = 1'b1;
   logic                     start     = 1'b0;
   logic [OP_W-1:0]          req_op    = '0;
   logic signed [DATA_W-1:0] req_value = '0;
   logic                     busy;
   logic                     rsp_strobe;
   logic signed [DATA_W-1:0] rsp_item;
   logic [STATUS_W-1:0]      rsp_status;
   logic                     rsp_last;

   // model state of the deque
   logic signed [DATA_W-1:0] ring_words [CAPACITY];
   int                       front_slot = 0;
   int                       fill_count = 0;

   deque_result_type pending_results [$];
   int               error_count = 0;
   int               cycle_count = 0;
   int               burst_left  = 0;

   double_ended_queue #(.CAPACITY(CAPACITY)) uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_op     (req_op),
      .req_value  (req_value),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .rsp_status (rsp_status),
      .rsp_last   (rsp_last)
   );

   // clock
   always #1 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAILURE");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      $display("cycle %0d: %s", cycle_count, what);
      error_count++;
   endtask

   function automatic void queue_result(input logic signed [DATA_W-1:0] item,
                                        input logic [STATUS_W-1:0] status, input logic last);
      deque_result_type r;
      r.item   = item;
      r.status = status;
      r.last   = last;
      pending_results.push_back(r);
   endfunction

   // update the deque model for one accepted request and queue its results
   function automatic void apply_deque_op(input logic [OP_W-1:0] op,
                                          input logic signed [DATA_W-1:0] value);
      int slot;
      case (op)
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (fill_count >= CAPACITY) begin
               queue_result('0, ST_FULL, 1'b1);
            end else begin
               if (op == OP_PUSH_FRONT) begin
                  front_slot = (front_slot + CAPACITY - 1) % CAPACITY;
                  slot = front_slot;
               end else begin
                  slot = (front_slot + fill_count) % CAPACITY;
               end
               ring_words[slot] = value;
               fill_count++;
               queue_result('0, ST_OK, 1'b1);
            end
         end
         OP_POP_FRONT: begin
            if (fill_count == 0) begin
               queue_result('0, ST_EMPTY, 1'b1);
            end else begin
               queue_result(ring_words[front_slot], ST_OK, 1'b1);
               front_slot = (front_slot + 1) % CAPACITY;
               fill_count--;
            end
         end
         OP_POP_BACK: begin
            if (fill_count == 0) begin
               queue_result('0, ST_EMPTY, 1'b1);
            end else begin
               slot = (front_slot + fill_count - 1) % CAPACITY;
               queue_result(ring_words[slot], ST_OK, 1'b1);
               fill_count--;
            end
         end
         OP_DUMP: begin
            if (fill_count == 0) begin
               queue_result('0, ST_EMPTY, 1'b1);
            end else begin
               for (int i = 0; i < fill_count; i++)
                  queue_result(ring_words[(front_slot + i) % CAPACITY], ST_OK,
                               i == fill_count - 1);
            end
         end
         default: ;
      endcase
   endfunction

   // send one request, idling between bursts; returns at the edge that takes it
   task automatic send_request(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] value);
      if (burst_left == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
         burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(40, 20) : $urandom_range(8, 1);
      end
      burst_left--;
      req_op    <= op;
      req_value <= value;
      start     <= 1'b1;
      do @(posedge clock); while (busy);
      apply_deque_op(op, value);
   endtask

   function automatic logic signed [DATA_W-1:0] random_word();
      case ($urandom_range(15, 0))
         0:       return WORD_MIN;
         1:       return WORD_MAX;
         2:       return '0;
         3:       return WORD_ONES;
         default: return $urandom;
      endcase
   endfunction

   // result checker: the receiver takes every strobe
   always @(posedge clock) begin
      deque_result_type want;
      if (!reset && rsp_strobe) begin
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result item %0d status %0d last %0d",
                                      rsp_item, rsp_status, rsp_last));
         end else begin
            want = pending_results.pop_front();
            if (rsp_item !== want.item)
               report_mismatch($sformatf("item %0d, expected %0d", rsp_item, want.item));
            if (rsp_status !== want.status)
               report_mismatch($sformatf("status %0d, expected %0d", rsp_status, want.status));
            if (rsp_last !== want.last)
               report_mismatch($sformatf("last %0d, expected %0d", rsp_last, want.last));
         end
      end
   end

   // pops and dump on an empty queue
   task automatic test_empty_queue();
      send_request(OP_POP_FRONT, random_word());
      send_request(OP_POP_BACK, random_word());
      send_request(OP_DUMP, random_word());
   endtask

   // pop of the only entry from either end
   task automatic test_single_entry();
      send_request(OP_PUSH_BACK, WORD_MIN);
      send_request(OP_POP_FRONT, random_word());
      send_request(OP_PUSH_FRONT, WORD_MAX);
      send_request(OP_POP_BACK, random_word());
   endtask

   // fill from both ends, refuse pushes when full, dump all entries
   task automatic test_fill_to_capacity();
      send_request(OP_PUSH_FRONT, '0);
      send_request(OP_PUSH_BACK, WORD_ONES);
      for (int i = 2; i < CAPACITY; i++)
         send_request(i[0] ? OP_PUSH_BACK : OP_PUSH_FRONT, random_word());
      send_request(OP_PUSH_FRONT, random_word());
      send_request(OP_PUSH_BACK, random_word());
      send_request(OP_DUMP, random_word());
   endtask

   // unused op code must leave the queue alone
   task automatic test_unused_code();
      send_request(OP_UNUSED_HI, random_word());
   endtask

   // random traffic that alternates between filling and draining stretches
   task automatic test_random_traffic();
      int              taken;
      int              segment_left;
      bit              filling;
      int              pick;
      logic [OP_W-1:0] op;
      taken        = 0;
      segment_left = 0;
      filling      = 1'b1;
      while (taken < RANDOM_ITEMS) begin
         if (segment_left == 0) begin
            filling      = ~filling;
            segment_left = $urandom_range(40, 10);
         end
         pick = $urandom_range(99, 0);
         if (pick < 4)
            op = OP_W'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
         else if (pick < 14)
            op = OP_DUMP;
         else if (pick < (filling ? 74 : 40))
            op = $urandom_range(1, 0) ? OP_PUSH_FRONT : OP_PUSH_BACK;
         else
            op = $urandom_range(1, 0) ? OP_POP_FRONT : OP_POP_BACK;
         send_request(op, random_word());
         if (op <= OP_DUMP)
            taken++;
         segment_left--;
      end
   endtask

   // test sequence
   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_empty_queue();
      test_single_entry();
      test_fill_to_capacity();
      test_unused_code();
      test_random_traffic();
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

`default_nettype wire

// File: filelist.f
+incdir+rtl/core
rtl/core/dq_pkg.sv
rtl/core/dq_cell.sv
rtl/core/double_ended_queue.sv
rtl/core/dq_checker.sv
tb/sv/tb_double_ended_queue.sv
